// File: rtl/core/cmdfrm_pkg.sv
// Shared types, constants and the CRC-16/MCRF4XX byte update for the command framer.
`default_nettype none

package cmdfrm_pkg;

  // Largest payload a frame may carry.
  localparam logic [7:0] MAX_PAYLOAD = 8'd251;

  // The length byte counts the payload plus address, command and both CRC bytes.
  localparam logic [7:0] FRAME_OVERHEAD = 8'd4;

  // Reflected CRC-16/MCRF4XX: polynomial 0x8408, initial value 0xFFFF, no final xor.
  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Input transaction kinds.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LONG  = 2'd1,
    STATUS_OUT_OF_SEQ = 2'd2
  } status_t;

  // Position of the byte being emitted inside the frame. A data transaction
  // enters at STEP_BODY, a start transaction at STEP_LEN.
  typedef enum logic [2:0] {
    STEP_LEN    = 3'd0,
    STEP_ADDR   = 3'd1,
    STEP_BODY   = 3'd2,
    STEP_CRC_LO = 3'd3,
    STEP_CRC_HI = 3'd4
  } step_t;

  // One byte through the reflected CRC, bit by bit, low bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/command_framer_crc16_mcrf4xx_core.sv
// Top level of the length-prefixed command framer with CRC-16/MCRF4XX trailer.
`default_nettype none

// The framer turns start and data transactions into a byte stream of reader
// command frames. A start transaction (kind 0) produces the length byte
// (payload_size plus 4), dest_address and command_code; each data transaction
// (kind 1) produces its payload_byte; after the last payload byte, or right
// after the header when payload_size is 0, the two CRC-16/MCRF4XX bytes follow,
// low byte first, with frame_end set on the high byte. The CRC covers every
// earlier byte of the frame. A start with payload_size above 251 yields one
// byte with status 1 and opens nothing; a data transaction with no frame open,
// or a start while a frame is open, yields one byte with status 2 and is
// otherwise ignored. Error results carry frame_byte 0 and frame_end 0.
// Timing: the block emits one output byte per cycle while out_stall is low. A
// transaction is held in an input register until it has emitted all its bytes:
// one for a payload byte or an error, three for a start that opens a frame,
// three for the last payload byte and five for a start with an empty payload.
// The CRC is updated one byte per cycle under the same condition by an unrolled
// 8-bit update. An output register separates the sides, so a new transaction is
// taken in the cycle in which the previous one's last byte enters that register.
module command_framer_crc16_mcrf4xx_core
  import cmdfrm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // Input channel.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       kind,
  input  wire logic [7:0] dest_address,
  input  wire logic [7:0] command_code,
  input  wire logic [7:0] payload_size,
  input  wire logic [7:0] payload_byte,
  // Output channel.
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      frame_byte,
  output logic            frame_end,
  output logic [1:0]      status
);

  // Held input transaction and the position of the next byte it emits.
  logic        item_valid;
  logic        item_kind;
  logic [7:0]  item_addr;
  logic [7:0]  item_cmd;
  logic [7:0]  item_size;
  logic [7:0]  item_pbyte;
  step_t       step;

  // Frame state.
  logic [15:0] crc;
  logic [7:0]  bytes_remaining;
  logic        frame_open;

  logic [15:0] crc_next;
  logic [7:0]  bytes_remaining_next;
  logic        frame_open_next;

  // Output register.
  logic [7:0]  out_byte;
  logic        out_end;
  status_t     out_status;

  // Byte produced this cycle by the held transaction.
  logic [7:0]  emit_byte;
  logic        emit_end;
  status_t     emit_status;
  logic        emit_last;
  logic        emit_crc_upd;
  logic [15:0] crc_in;

  logic        advance;
  logic        is_start;
  logic        take;

  // The output register can load when it is empty or its byte leaves now.
  assign advance  = !out_valid || !out_stall;
  assign is_start = (item_kind == KIND_START);

  // A new transaction enters when the held one is gone or emits its last byte now.
  assign in_stall = item_valid && !(advance && emit_last);
  assign take     = in_valid && !in_stall;

  // The length byte starts a fresh CRC; every other header or payload byte
  // continues the running one.
  assign crc_in = (is_start && step == STEP_LEN) ? CRC_INIT : crc;

  always_comb begin
    emit_byte            = 8'h00;
    emit_end             = 1'b0;
    emit_status          = STATUS_OK;
    emit_last            = 1'b1;
    emit_crc_upd         = 1'b0;
    bytes_remaining_next = bytes_remaining;
    frame_open_next      = frame_open;
    crc_next             = crc;

    if (is_start && frame_open) begin
      emit_status = STATUS_OUT_OF_SEQ;
    end else if (is_start && item_size > MAX_PAYLOAD) begin
      emit_status = STATUS_TOO_LONG;
    end else if (!is_start && !frame_open) begin
      emit_status = STATUS_OUT_OF_SEQ;
    end else begin
      case (step)
        STEP_LEN: begin
          emit_byte    = item_size + FRAME_OVERHEAD;
          emit_crc_upd = 1'b1;
          emit_last    = 1'b0;
        end
        STEP_ADDR: begin
          emit_byte    = item_addr;
          emit_crc_upd = 1'b1;
          emit_last    = 1'b0;
        end
        STEP_BODY: begin
          emit_crc_upd = 1'b1;
          if (is_start) begin
            emit_byte = item_cmd;
            // An empty payload runs straight on into the CRC bytes.
            emit_last = (item_size != 8'd0);
            if (item_size != 8'd0) begin
              frame_open_next      = 1'b1;
              bytes_remaining_next = item_size;
            end
          end else begin
            emit_byte            = item_pbyte;
            emit_last            = (bytes_remaining != 8'd1);
            bytes_remaining_next = bytes_remaining - 8'd1;
          end
        end
        STEP_CRC_LO: begin
          emit_byte = crc[7:0];
          emit_last = 1'b0;
        end
        STEP_CRC_HI: begin
          emit_byte            = crc[15:8];
          emit_end             = 1'b1;
          crc_next             = CRC_INIT;
          frame_open_next      = 1'b0;
          bytes_remaining_next = 8'd0;
        end
        default: begin
          emit_byte = 8'h00;
        end
      endcase
      if (emit_crc_upd) begin
        crc_next = crc_byte(crc_in, emit_byte);
      end
    end
  end

  // Held transaction and its byte position.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      step       <= STEP_LEN;
    end else if (take) begin
      item_valid <= 1'b1;
      step       <= (kind == KIND_START) ? STEP_LEN : STEP_BODY;
    end else if (item_valid && advance) begin
      if (emit_last) begin
        item_valid <= 1'b0;
      end else begin
        step <= step_t'(step + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_kind  <= kind;
      item_addr  <= dest_address;
      item_cmd   <= command_code;
      item_size  <= payload_size;
      item_pbyte <= payload_byte;
    end
  end

  // Frame state moves on with every emitted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc             <= CRC_INIT;
      bytes_remaining <= 8'd0;
      frame_open      <= 1'b0;
    end else if (item_valid && advance) begin
      crc             <= crc_next;
      bytes_remaining <= bytes_remaining_next;
      frame_open      <= frame_open_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      out_byte   <= emit_byte;
      out_end    <= emit_end;
      out_status <= emit_status;
    end
  end

  assign frame_byte = out_byte;
  assign frame_end  = out_end;
  assign status     = out_status;

endmodule

`default_nettype wire
